>>> design/apsh_pkg.sv
`timescale 1ns / 1ps

package apsh_pkg;

   localparam int IDX_W      = 5;
   localparam int DATA_W     = 32;
   localparam int ADDR_LIMIT = 32;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_REPORT = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                  kind;
      logic [IDX_W-1:0]          index;
      logic signed [DATA_W-1:0]  write_data;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_data;
      logic [IDX_W-1:0]          hot_index;
      logic                      hot_found;
      logic                      last;
   } rsp_type;

endpackage

>>> design/access_profiled_store_hotspots_top.sv
`timescale 1ns / 1ps

// access-counting word store with hot-spot report
// request channel: req_item is taken at a rising edge with start high and busy low
//   kind read or write: accesses entry index, bumps its access counter (unless saturated) and the sums
//   kind report: walks the entries and lists every index whose count is at least
//   mean plus population standard deviation of all SIZE counts
// result channel: rsp_valid marks rsp_item for exactly one cycle; the receiver
//   cannot stall, so every result is a transfer in the cycle it is shown
// access: one result, registered in the ST_ACC state that follows acceptance; busy
//   drops in the cycle the result is shown, so a new access is taken only once the
//   last one's result is shown (counter memory read, then modify and write back)
// report: setup states ST_PREP and ST_VAR for the variance term, then one counter
//   memory read per cycle over min(SIZE,32) entries feeding a three stage
//   difference/square/compare pipeline; hot indices come out at most one per
//   cycle, the final one flagged last
// an empty report gives one result with hot_found low and last high
// accesses with index beyond the store, and kind 3, give no result
// reset: counters read as zero through per-entry valid flags, sums cleared;
//   stored words are undefined until written
module access_profiled_store_hotspots_top
   import apsh_pkg::*;
#(
   parameter int SIZE       = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int ADDR_N = (SIZE < ADDR_LIMIT) ? SIZE : ADDR_LIMIT;
   localparam int AW     = (ADDR_N > 1) ? $clog2(ADDR_N) : 1;
   localparam int SZW    = $clog2(SIZE + 1);
   localparam int NW     = $clog2(ADDR_N + 1);
   localparam int SUM_W  = COUNT_BITS + NW;
   localparam int SQ_W   = 2 * COUNT_BITS + NW;
   localparam int PW     = COUNT_BITS + SZW;
   localparam int VW     = 2 * PW;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [IDX_W:0]        IDX_LIM   = (IDX_W + 1)'(ADDR_N);
   localparam logic [AW-1:0]         LAST_ADDR = AW'(ADDR_N - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_PREP,
      ST_VAR,
      ST_WALK
   } state_type;

   state_type state_ff;

   // memories
   logic [COUNT_BITS-1:0] cnt_mem  [ADDR_N];
   logic [DATA_W-1:0]     word_mem [ADDR_N];
   logic [ADDR_N-1:0]     cnt_valid_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic                  cnt_vld_ff;
   logic [DATA_W-1:0]     word_rd_ff;
   logic [AW-1:0]         acc_idx_ff;

   // statistics
   logic [SUM_W-1:0]      sum_ff;
   logic [SQ_W-1:0]       sumsq_ff;
   logic [VW-1:0]         sq_scaled_ff;
   logic [VW-1:0]         sum2_ff;
   logic [VW-1:0]         var_ff;

   // walk pipeline
   logic [AW-1:0]         walk_idx_ff;
   logic                  issue_on_ff;
   logic                  s1_v_ff;
   logic                  s2_v_ff;
   logic                  s3_v_ff;
   logic [AW-1:0]         s1_idx_ff;
   logic [AW-1:0]         s2_idx_ff;
   logic [AW-1:0]         s3_idx_ff;
   logic [PW-1:0]         s2_mag_ff;
   logic                  s2_neg_ff;
   logic [VW-1:0]         s3_dsq_ff;
   logic                  s3_neg_ff;
   logic                  pend_v_ff;
   logic [AW-1:0]         pend_idx_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  acc_go;
   logic                  rep_go;
   logic                  in_range;
   logic [AW-1:0]         raddr;
   logic [COUNT_BITS-1:0] cnt_cur;
   logic                  cnt_we;
   logic [PW-1:0]         scaled;
   logic [PW:0]           diff;
   logic [2*SUM_W-1:0]    sum_sq;
   logic                  hit;
   logic                  walk_end;

   assign busy      = (state_ff != ST_IDLE);
   assign in_range  = ({1'b0, req_item.index} < IDX_LIM);
   assign acc_go    = start && !busy && in_range &&
                      (req_item.kind == KIND_READ || req_item.kind == KIND_WRITE);
   assign rep_go    = start && !busy && (req_item.kind == KIND_REPORT);
   assign raddr     = (state_ff == ST_WALK) ? walk_idx_ff : req_item.index[AW-1:0];
   assign cnt_cur   = cnt_vld_ff ? cnt_rd_ff : '0;
   assign cnt_we    = (state_ff == ST_ACC) && (cnt_cur != COUNT_MAX);
   assign scaled    = PW'(cnt_cur) * PW'(SIZE);
   assign diff      = {1'b0, scaled} - {1'b0, PW'(sum_ff)};
   assign sum_sq    = sum_ff * sum_ff;
   assign hit       = s3_v_ff && !s3_neg_ff && (s3_dsq_ff >= var_ff);
   assign walk_end  = (state_ff == ST_WALK) && !issue_on_ff &&
                      !s1_v_ff && !s2_v_ff && !s3_v_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[acc_idx_ff] <= cnt_cur + 1'b1;
      end
      cnt_rd_ff <= cnt_mem[raddr];
      if (acc_go && req_item.kind == KIND_WRITE) begin
         word_mem[req_item.index[AW-1:0]] <= req_item.write_data;
      end
      if (acc_go) begin
         word_rd_ff <= (req_item.kind == KIND_WRITE) ? req_item.write_data
                                                     : word_mem[req_item.index[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
      end else if (cnt_we) begin
         cnt_valid_ff[acc_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cnt_vld_ff   <= cnt_valid_ff[raddr];
      if (acc_go) begin
         acc_idx_ff <= req_item.index[AW-1:0];
      end
      sq_scaled_ff <= VW'(sumsq_ff) * VW'(SIZE);
      sum2_ff      <= VW'(sum_sq);
      var_ff       <= (state_ff == ST_VAR) ? sq_scaled_ff - sum2_ff : var_ff;
      s1_idx_ff    <= walk_idx_ff;
      s2_idx_ff    <= s1_idx_ff;
      s2_mag_ff    <= diff[PW-1:0];
      s2_neg_ff    <= diff[PW];
      s3_idx_ff    <= s2_idx_ff;
      s3_dsq_ff    <= s2_mag_ff * s2_mag_ff;
      s3_neg_ff    <= s2_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         issue_on_ff  <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         s1_v_ff      <= (state_ff == ST_WALK) && issue_on_ff;
         s2_v_ff      <= s1_v_ff;
         s3_v_ff      <= s2_v_ff;
         case (state_ff)
            ST_IDLE: begin
               if (acc_go) begin
                  state_ff <= ST_ACC;
               end else if (rep_go) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_ACC: begin
               if (cnt_we) begin
                  sum_ff   <= sum_ff + 1'b1;
                  sumsq_ff <= sumsq_ff + SQ_W'({cnt_cur, 1'b1});
               end
               rsp_valid_ff      <= 1'b1;
               rsp_ff.read_data  <= $signed(word_rd_ff);
               rsp_ff.hot_index  <= '0;
               rsp_ff.hot_found  <= 1'b0;
               rsp_ff.last       <= 1'b1;
               state_ff          <= ST_IDLE;
            end
            ST_PREP: begin
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               walk_idx_ff <= '0;
               issue_on_ff <= 1'b1;
               pend_v_ff   <= 1'b0;
               state_ff    <= ST_WALK;
            end
            ST_WALK: begin
               if (issue_on_ff) begin
                  if (walk_idx_ff == LAST_ADDR) begin
                     issue_on_ff <= 1'b0;
                  end else begin
                     walk_idx_ff <= walk_idx_ff + 1'b1;
                  end
               end
               if (hit) begin
                  if (pend_v_ff) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_ff.read_data <= '0;
                     rsp_ff.hot_index <= IDX_W'(pend_idx_ff);
                     rsp_ff.hot_found <= 1'b1;
                     rsp_ff.last      <= 1'b0;
                  end
                  pend_v_ff   <= 1'b1;
                  pend_idx_ff <= s3_idx_ff;
               end
               if (walk_end) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_ff.read_data <= '0;
                  rsp_ff.hot_index <= pend_v_ff ? IDX_W'(pend_idx_ff) : '0;
                  rsp_ff.hot_found <= pend_v_ff;
                  rsp_ff.last      <= 1'b1;
                  pend_v_ff        <= 1'b0;
                  state_ff         <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_acc_result: assert property (@(posedge clock) disable iff (reset)
      acc_go |=> ##1 (rsp_valid && rsp_item.last))
      else $error("access transfer without its result");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.hot_found) |-> rsp_item.last)
      else $error("empty result not flagged last");

   a_var_nonneg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_VAR) |-> (sq_scaled_ff >= sum2_ff))
      else $error("variance term negative, sums out of step");

   a_pipe_walk: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff || s2_v_ff || s3_v_ff) |-> (state_ff == ST_WALK))
      else $error("walk pipeline active outside report");
`endif

endmodule

>>> tb/access_profiled_store_hotspots_top_tb.sv
`timescale 1ns / 1ps

module access_profiled_store_hotspots_top_tb
   import apsh_pkg::*;
();

   localparam int STORE_SIZE = 32;
   localparam int COUNT_BITS = 16;
   localparam int BURST_ACCESSES = 16;

   typedef struct {
      req_type item;
      bit      hold_for_drain;
      bit      may_idle;
   } request_entry_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   access_profiled_store_hotspots_top #(
      .SIZE       (STORE_SIZE),
      .COUNT_BITS (COUNT_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   request_entry_type outgoing[$];
   rsp_type           expected_results[$];
   int                mismatches = 0;

   // predicted block state
   logic signed [DATA_W-1:0] store_word [STORE_SIZE];
   logic [COUNT_BITS-1:0]    access_count [STORE_SIZE];
   logic [20:0]              count_total;
   logic [36:0]              square_total;

   // generator bookkeeping: entries that hold a written word
   bit stored [STORE_SIZE];

   logic req_taken;
   int   idle_left = 0;
   bit   sent_may_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      start    = 1'b0;
      req_item = '0;
   end

   function automatic bit is_hot(logic [COUNT_BITS-1:0] c);
      longint dev;
      longint spread;
      dev    = longint'(c) * STORE_SIZE - longint'(count_total);
      spread = longint'(square_total) * STORE_SIZE
               - longint'(count_total) * longint'(count_total);
      return dev >= 0 && dev * dev >= spread;
   endfunction

   task automatic profile_step(req_type r);
      rsp_type res;
      int      hits;
      res  = '0;
      hits = 0;
      case (r.kind)
         KIND_READ, KIND_WRITE: begin
            if (int'(r.index) < STORE_SIZE) begin
               if (access_count[r.index] != '1) begin
                  square_total = square_total + {access_count[r.index], 1'b0} + 37'd1;
                  count_total  = count_total + 21'd1;
                  access_count[r.index] = access_count[r.index] + 1'b1;
               end
               if (r.kind == KIND_WRITE)
                  store_word[r.index] = r.write_data;
               res.read_data = store_word[r.index];
               res.last      = 1'b1;
               expected_results.push_back(res);
            end
         end
         KIND_REPORT: begin
            for (int i = 0; i < STORE_SIZE && i < ADDR_LIMIT; i++) begin
               if (is_hot(access_count[i])) begin
                  res.hot_index = IDX_W'(i);
                  res.hot_found = 1'b1;
                  expected_results.push_back(res);
                  hits++;
               end
            end
            if (hits == 0) begin
               res.last = 1'b1;
               expected_results.push_back(res);
            end else begin
               expected_results[expected_results.size() - 1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // driver
   always @(negedge clock) begin
      logic              launch;
      request_entry_type next_entry;
      launch = 1'b0;
      if (!reset && !(start && !req_taken)) begin
         if (start && req_taken && sent_may_idle && $urandom_range(0, 2) == 0)
            idle_left = $urandom_range(1, 18);
         if (idle_left > 0) begin
            idle_left--;
         end else if (outgoing.size() > 0 &&
                      (!outgoing[0].hold_for_drain || expected_results.size() == 0)) begin
            launch = 1'b1;
         end
         if (launch) begin
            next_entry    = outgoing.pop_front();
            req_item      <= next_entry.item;
            sent_may_idle = next_entry.may_idle;
         end
         start <= launch;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken    <= 1'b0;
         count_total  = '0;
         square_total = '0;
         for (int i = 0; i < STORE_SIZE; i++) begin
            access_count[i] = '0;
            store_word[i]   = '0;
         end
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.read_data !== want.read_data) begin
                  $error("read_data expected %0d actual %0d", want.read_data,
                         rsp_item.read_data);
                  mismatches++;
               end
               if (rsp_item.hot_index !== want.hot_index) begin
                  $error("hot_index expected %0d actual %0d", want.hot_index,
                         rsp_item.hot_index);
                  mismatches++;
               end
               if (rsp_item.hot_found !== want.hot_found) begin
                  $error("hot_found expected %0d actual %0d", want.hot_found,
                         rsp_item.hot_found);
                  mismatches++;
               end
               if (rsp_item.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_item.last);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            profile_step(req_item);
      end
   end

   task automatic queue_item(kind_type k, int idx, logic [DATA_W-1:0] data,
                             bit drain, bit may_idle);
      request_entry_type e;
      e.item.kind       = k;
      e.item.index      = IDX_W'(idx);
      e.item.write_data = data;
      e.hold_for_drain  = drain;
      e.may_idle        = may_idle;
      if (k == KIND_WRITE)
         stored[idx] = 1'b1;
      outgoing.push_back(e);
   endtask

   initial begin
      int       idx;
      int       roll;
      int       spot [3];
      bit       idle_stretch;
      kind_type k;

      reset = 1'b1;
      for (int i = 0; i < STORE_SIZE; i++)
         stored[i] = 1'b0;

      // all counts zero: every entry is hot
      queue_item(KIND_REPORT, 0, '0, 1'b0, 1'b1);
      queue_item(KIND_WRITE, 0, 32'h8000_0000, 1'b0, 1'b1);
      queue_item(KIND_WRITE, 31, 32'h7FFF_FFFF, 1'b0, 1'b0);
      queue_item(KIND_WRITE, 1, 32'hFFFF_FFFF, 1'b0, 1'b0);
      queue_item(KIND_WRITE, 2, 32'h0000_0000, 1'b0, 1'b1);
      for (int i = 3; i < 16; i++)
         queue_item(KIND_WRITE, i, $urandom, 1'b0, i[0]);
      // seventeen entries at one: nothing reaches mean plus deviation
      queue_item(KIND_REPORT, 31, $urandom, 1'b0, 1'b1);
      queue_item(KIND_READ, 0, $urandom, 1'b0, 1'b0);
      queue_item(KIND_READ, 31, $urandom, 1'b0, 1'b1);
      queue_item(KIND_UNUSED, 21, $urandom, 1'b0, 1'b0);
      queue_item(KIND_REPORT, 10, $urandom, 1'b0, 1'b1);

      // random traffic with drifting hot spots
      idle_stretch = 1'b1;
      for (int n = 0; n < 280; n++) begin
         if (n % 70 == 0) begin
            for (int j = 0; j < 3; j++)
               spot[j] = $urandom_range(0, STORE_SIZE - 1);
         end
         if (n % 40 == 0)
            idle_stretch = $urandom_range(0, 2) != 0;
         if ($urandom_range(0, 1) == 0)
            idx = spot[$urandom_range(0, 2)];
         else
            idx = $urandom_range(0, STORE_SIZE - 1);
         roll = $urandom_range(0, 99);
         if (roll < 8)
            k = KIND_REPORT;
         else if (roll < 11)
            k = KIND_UNUSED;
         else if (!stored[idx] || $urandom_range(0, 1) == 0)
            k = KIND_WRITE;
         else
            k = KIND_READ;
         queue_item(k, idx, $urandom, n == 140, idle_stretch);
      end
      queue_item(KIND_REPORT, 0, '0, 1'b0, 1'b1);

      // burst on one entry, no idling from here on
      for (int n = 0; n < BURST_ACCESSES; n++) begin
         k = ($urandom_range(0, 1) == 0) ? KIND_WRITE : KIND_READ;
         queue_item(k, 31, $urandom, n == 0, 1'b0);
         if (n == BURST_ACCESSES / 2 || n == BURST_ACCESSES - 1)
            queue_item(KIND_REPORT, 0, '0, 1'b0, 1'b0);
      end
      queue_item(KIND_READ, 0, '0, 1'b0, 1'b0);
      queue_item(KIND_WRITE, 5, $urandom, 1'b0, 1'b0);
      queue_item(KIND_READ, 31, '0, 1'b0, 1'b0);
      queue_item(KIND_REPORT, 0, '0, 1'b0, 1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (outgoing.size() != 0 || start === 1'b1 || expected_results.size() != 0)
         @(posedge clock);
      repeat (64) @(posedge clock);

      if (mismatches == 0)
         $display("access_profiled_store_hotspots_top_tb passed");
      else
         $display("access_profiled_store_hotspots_top_tb failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("access_profiled_store_hotspots_top_tb failed");
      $finish;
   end

endmodule

>>> access_profiled_store_hotspots_top.f
design/apsh_pkg.sv
design/access_profiled_store_hotspots_top.sv
tb/access_profiled_store_hotspots_top_tb.sv
